FILE: hdl/scac_pkg.sv
// Shared types and constants for the stereo correlation accumulator.
`timescale 1ns / 1ps

package scac_pkg;

  // Fixed port widths of the sample and result fields.
  localparam int SAMPLE_PORT_BITS = 16;
  localparam int TOTAL_COUNT_BITS = 28;
  localparam int SUM_BITS         = 46;
  localparam int SQ_BITS          = 61;
  localparam int XY_BITS          = 62;

  // APB data and address widths.
  localparam int APB_DATA_BITS = 32;
  localparam int APB_ADDR_BITS = 3;

  // Register index, taken from paddr[2].
  typedef enum logic {
    REG_DIFFERENCE_MODE = 1'b0,
    REG_MONO_MODE       = 1'b1
  } reg_idx_t;

  // Mode settings from the register block.
  typedef struct packed {
    logic difference_mode;
    logic mono_mode;
  } cfg_t;

  // Block framing flags that travel with each sample.
  typedef struct packed {
    logic start_block;
    logic last_sample;
  } flags_t;

endpackage

FILE: hdl/scac_cfg_regs.sv
// APB register block holding the difference and mono mode bits.
`timescale 1ns / 1ps

module scac_cfg_regs (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [scac_pkg::APB_ADDR_BITS-1:0]   paddr,
  input  logic [scac_pkg::APB_DATA_BITS-1:0]   pwdata,
  output logic [scac_pkg::APB_DATA_BITS-1:0]   prdata,
  output logic                                 pready,
  output scac_pkg::cfg_t                       cfg
);

  scac_pkg::cfg_t   cfg_r;
  scac_pkg::reg_idx_t reg_idx;
  logic             wr_en;

  assign pready  = 1'b1;
  assign reg_idx = scac_pkg::reg_idx_t'(paddr[2]);
  assign wr_en   = psel && penable && pwrite && pready;
  assign cfg     = cfg_r;

  // Register writes complete in the access phase.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        scac_pkg::REG_DIFFERENCE_MODE: cfg_r.difference_mode <= pwdata[0];
        scac_pkg::REG_MONO_MODE:       cfg_r.mono_mode       <= pwdata[0];
        default:                       cfg_r                 <= cfg_r;
      endcase
    end
  end

  // Read data mux.
  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      scac_pkg::REG_DIFFERENCE_MODE: prdata[0] = cfg_r.difference_mode;
      scac_pkg::REG_MONO_MODE:       prdata[0] = cfg_r.mono_mode;
      default:                       prdata    = '0;
    endcase
  end

endmodule

FILE: hdl/scac_front.sv
// Input stage and product stage: forms x and y, then the three products.
`timescale 1ns / 1ps

module scac_front #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  scac_pkg::cfg_t                              cfg,
  input  logic                                        in_valid,
  output logic                                        in_stall,
  input  logic [scac_pkg::SAMPLE_PORT_BITS-1:0]       in_left_sample,
  input  logic [scac_pkg::SAMPLE_PORT_BITS-1:0]       in_right_sample,
  input  logic                                        in_start_block,
  input  logic                                        in_last_sample,
  output logic                                        term_valid,
  input  logic                                        term_take,
  output scac_pkg::flags_t                            term_flags,
  output logic [scac_pkg::SUM_BITS-1:0]               term_x,
  output logic [scac_pkg::SQ_BITS-1:0]                term_xx,
  output logic [scac_pkg::SUM_BITS-1:0]               term_y,
  output logic [scac_pkg::SQ_BITS-1:0]                term_yy,
  output logic [scac_pkg::XY_BITS-1:0]                term_xy
);

  localparam int XW = SAMPLE_BITS + 1;
  localparam int PW = 2 * XW;

  // Previous samples, kept across blocks.
  logic signed [SAMPLE_BITS-1:0] prev_left_r, prev_right_r;
  logic signed [SAMPLE_BITS-1:0] left_s, right_s;
  logic signed [XW-1:0]          x_nxt, y_nxt;

  // Stage A: differences.
  logic                 a_valid_r;
  logic signed [XW-1:0] a_x_r, a_y_r;
  scac_pkg::flags_t     a_flags_r;

  // Stage B: products.
  logic                 b_valid_r;
  logic signed [XW-1:0] b_x_r, b_y_r;
  logic signed [PW-1:0] b_xx_r, b_yy_r, b_xy_r;
  scac_pkg::flags_t     b_flags_r;

  logic a_adv, b_adv, in_xfer;

  assign b_adv    = !b_valid_r || term_take;
  assign a_adv    = !a_valid_r || b_adv;
  assign in_stall = !a_adv;
  assign in_xfer  = in_valid && a_adv;

  assign left_s  = $signed(in_left_sample[SAMPLE_BITS-1:0]);
  assign right_s = $signed(in_right_sample[SAMPLE_BITS-1:0]);

  // Raw or first-difference values; mono mode copies x into y.
  always_comb begin
    if (cfg.difference_mode) begin
      x_nxt = XW'(left_s) - XW'(prev_left_r);
    end else begin
      x_nxt = XW'(left_s);
    end
    if (cfg.mono_mode) begin
      y_nxt = x_nxt;
    end else if (cfg.difference_mode) begin
      y_nxt = XW'(right_s) - XW'(prev_right_r);
    end else begin
      y_nxt = XW'(right_s);
    end
  end

  // Previous sample registers load on every accepted transfer; the right one holds in mono mode.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_left_r  <= '0;
      prev_right_r <= '0;
    end else if (in_xfer) begin
      prev_left_r <= left_s;
      if (!cfg.mono_mode) begin
        prev_right_r <= right_s;
      end
    end
  end

  // Stage A register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (a_adv) begin
      a_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      a_x_r     <= x_nxt;
      a_y_r     <= y_nxt;
      a_flags_r <= '{start_block: in_start_block, last_sample: in_last_sample};
    end
  end

  // Stage B register with the three multipliers in front of it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (b_adv) begin
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (b_adv && a_valid_r) begin
      b_x_r     <= a_x_r;
      b_y_r     <= a_y_r;
      b_xx_r    <= a_x_r * a_x_r;
      b_yy_r    <= a_y_r * a_y_r;
      b_xy_r    <= a_x_r * a_y_r;
      b_flags_r <= a_flags_r;
    end
  end

  // Sign-extended terms for the accumulators.
  assign term_valid = b_valid_r;
  assign term_flags = b_flags_r;
  assign term_x     = scac_pkg::SUM_BITS'(b_x_r);
  assign term_y     = scac_pkg::SUM_BITS'(b_y_r);
  assign term_xx    = scac_pkg::SQ_BITS'(b_xx_r);
  assign term_yy    = scac_pkg::SQ_BITS'(b_yy_r);
  assign term_xy    = scac_pkg::XY_BITS'(b_xy_r);

endmodule

FILE: hdl/scac_accum.sv
// Moment accumulators with count saturation and the result register.
`timescale 1ns / 1ps

module scac_accum #(
  parameter int COUNT_BITS = 28
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        term_valid,
  output logic                                        term_take,
  input  scac_pkg::flags_t                            term_flags,
  input  logic [scac_pkg::SUM_BITS-1:0]               term_x,
  input  logic [scac_pkg::SQ_BITS-1:0]                term_xx,
  input  logic [scac_pkg::SUM_BITS-1:0]               term_y,
  input  logic [scac_pkg::SQ_BITS-1:0]                term_yy,
  input  logic [scac_pkg::XY_BITS-1:0]                term_xy,
  output logic                                        out_valid,
  input  logic                                        out_stall,
  output logic        [scac_pkg::TOTAL_COUNT_BITS-1:0] out_sample_total,
  output logic signed [scac_pkg::SUM_BITS-1:0]        out_total_x,
  output logic        [scac_pkg::SQ_BITS-1:0]         out_total_x_squared,
  output logic signed [scac_pkg::SUM_BITS-1:0]        out_total_y,
  output logic        [scac_pkg::SQ_BITS-1:0]         out_total_y_squared,
  output logic signed [scac_pkg::XY_BITS-1:0]         out_total_xy,
  output logic                                        out_overflow
);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  logic [COUNT_BITS-1:0]         count_r, count_base, count_nxt;
  logic [scac_pkg::SUM_BITS-1:0] sum_x_r, sum_x_base, sum_x_nxt;
  logic [scac_pkg::SUM_BITS-1:0] sum_y_r, sum_y_base, sum_y_nxt;
  logic [scac_pkg::SQ_BITS-1:0]  sum_xx_r, sum_xx_base, sum_xx_nxt;
  logic [scac_pkg::SQ_BITS-1:0]  sum_yy_r, sum_yy_base, sum_yy_nxt;
  logic [scac_pkg::XY_BITS-1:0]  sum_xy_r, sum_xy_base, sum_xy_nxt;
  logic                          ovf_r, ovf_nxt, saturated;
  logic                          out_valid_r;
  logic                          retire;

  // A block-ending sample waits while an earlier result is still held.
  assign term_take = !(term_flags.last_sample && out_valid_r && out_stall);
  assign retire    = term_valid && term_take;

  // Start of block clears the sums before this sample is added.
  always_comb begin
    if (term_flags.start_block) begin
      count_base  = '0;
      sum_x_base  = '0;
      sum_y_base  = '0;
      sum_xx_base = '0;
      sum_yy_base = '0;
      sum_xy_base = '0;
    end else begin
      count_base  = count_r;
      sum_x_base  = sum_x_r;
      sum_y_base  = sum_y_r;
      sum_xx_base = sum_xx_r;
      sum_yy_base = sum_yy_r;
      sum_xy_base = sum_xy_r;
    end
    saturated = (count_base == COUNT_MAX);
    ovf_nxt   = (ovf_r && !term_flags.start_block) || saturated;
    if (saturated) begin
      count_nxt  = count_base;
      sum_x_nxt  = sum_x_base;
      sum_y_nxt  = sum_y_base;
      sum_xx_nxt = sum_xx_base;
      sum_yy_nxt = sum_yy_base;
      sum_xy_nxt = sum_xy_base;
    end else begin
      count_nxt  = count_base + COUNT_BITS'(1);
      sum_x_nxt  = sum_x_base + term_x;
      sum_y_nxt  = sum_y_base + term_y;
      sum_xx_nxt = sum_xx_base + term_xx;
      sum_yy_nxt = sum_yy_base + term_yy;
      sum_xy_nxt = sum_xy_base + term_xy;
    end
  end

  // Accumulator registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      sum_x_r  <= '0;
      sum_y_r  <= '0;
      sum_xx_r <= '0;
      sum_yy_r <= '0;
      sum_xy_r <= '0;
      ovf_r    <= 1'b0;
    end else if (retire) begin
      count_r  <= count_nxt;
      sum_x_r  <= sum_x_nxt;
      sum_y_r  <= sum_y_nxt;
      sum_xx_r <= sum_xx_nxt;
      sum_yy_r <= sum_yy_nxt;
      sum_xy_r <= sum_xy_nxt;
      ovf_r    <= ovf_nxt;
    end
  end

  // Result valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (retire && term_flags.last_sample) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload, loaded with the totals that include the last sample.
  always_ff @(posedge clk) begin
    if (retire && term_flags.last_sample) begin
      out_sample_total    <= scac_pkg::TOTAL_COUNT_BITS'(count_nxt);
      out_total_x         <= $signed(sum_x_nxt);
      out_total_x_squared <= sum_xx_nxt;
      out_total_y         <= $signed(sum_y_nxt);
      out_total_y_squared <= sum_yy_nxt;
      out_total_xy        <= $signed(sum_xy_nxt);
      out_overflow        <= ovf_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // The overflow flag is only ever set while the count sits at its limit.
  assert property (@(posedge clk) disable iff (!rst_n) ovf_r |-> (count_r == COUNT_MAX))
    else $error("overflow flag set below the count limit");

  // A held result is never overwritten by a new block total.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !(retire && term_flags.last_sample))
    else $error("pending result overwritten");

  // A sample that opens a block leaves a count of exactly one.
  assert property (@(posedge clk) disable iff (!rst_n)
    (retire && term_flags.start_block) |=> (count_r == COUNT_BITS'(1)))
    else $error("count after start of block is not one");

  // Below the limit each retired sample adds one to the count.
  assert property (@(posedge clk) disable iff (!rst_n)
    (retire && !term_flags.start_block && (count_r != COUNT_MAX))
      |=> (count_r == $past(count_r) + COUNT_BITS'(1)))
    else $error("count did not advance by one");

endmodule

FILE: hdl/stereo_correlation_accumulator.sv
// Top level of the stereo correlation moment accumulator.
`timescale 1ns / 1ps
//
// Accumulates count, sum x, sum x^2, sum y, sum y^2 and sum x*y over a block
// of stereo sample pairs. The input channel (in_valid / in_stall) carries one
// sample pair with start_block and last_sample framing flags. start_block
// clears the count, sums and overflow flag before the pair is added; a pair
// with last_sample produces one result transfer on the out_ channel holding
// the totals including that pair. Totals are not cleared by emission.
// The APB port sets difference_mode (address 0) and mono_mode (address 4);
// write them only while the block is idle.
// A final pair passes through stage A, stage B and then the result register.
// Throughput: one pair per cycle unless a stall holds the pipeline, bounded
// by the accumulator adder loop; the pipeline holds three multipliers in its
// second stage. When the receiver stalls, the held result stays put while
// non-final pairs keep flowing; a second final pair waits in the pipeline
// until the result is taken, and in_stall rises once the pipeline fills.
// Reset clears the mode registers, all sums, the previous samples and the
// pipeline valid flags.

module stereo_correlation_accumulator #(
  parameter int COUNT_BITS  = 28,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  logic                                         psel,
  input  logic                                         penable,
  input  logic                                         pwrite,
  input  logic [scac_pkg::APB_ADDR_BITS-1:0]           paddr,
  input  logic [scac_pkg::APB_DATA_BITS-1:0]           pwdata,
  output logic [scac_pkg::APB_DATA_BITS-1:0]           prdata,
  output logic                                         pready,
  input  logic                                         in_valid,
  output logic                                         in_stall,
  input  logic signed [scac_pkg::SAMPLE_PORT_BITS-1:0] in_left_sample,
  input  logic signed [scac_pkg::SAMPLE_PORT_BITS-1:0] in_right_sample,
  input  logic                                         in_start_block,
  input  logic                                         in_last_sample,
  output logic                                         out_valid,
  input  logic                                         out_stall,
  output logic        [scac_pkg::TOTAL_COUNT_BITS-1:0] out_sample_total,
  output logic signed [scac_pkg::SUM_BITS-1:0]         out_total_x,
  output logic        [scac_pkg::SQ_BITS-1:0]          out_total_x_squared,
  output logic signed [scac_pkg::SUM_BITS-1:0]         out_total_y,
  output logic        [scac_pkg::SQ_BITS-1:0]          out_total_y_squared,
  output logic signed [scac_pkg::XY_BITS-1:0]          out_total_xy,
  output logic                                         out_overflow
);

  scac_pkg::cfg_t                cfg;
  logic                          term_valid, term_take;
  scac_pkg::flags_t              term_flags;
  logic [scac_pkg::SUM_BITS-1:0] term_x, term_y;
  logic [scac_pkg::SQ_BITS-1:0]  term_xx, term_yy;
  logic [scac_pkg::XY_BITS-1:0]  term_xy;

  // Mode registers.
  scac_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Difference and product stages.
  scac_front #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_left_sample  (in_left_sample),
    .in_right_sample (in_right_sample),
    .in_start_block  (in_start_block),
    .in_last_sample  (in_last_sample),
    .term_valid      (term_valid),
    .term_take       (term_take),
    .term_flags      (term_flags),
    .term_x          (term_x),
    .term_xx         (term_xx),
    .term_y          (term_y),
    .term_yy         (term_yy),
    .term_xy         (term_xy)
  );

  // Accumulators and result register.
  scac_accum #(
    .COUNT_BITS (COUNT_BITS)
  ) u_accum (
    .clk                 (clk),
    .rst_n               (rst_n),
    .term_valid          (term_valid),
    .term_take           (term_take),
    .term_flags          (term_flags),
    .term_x              (term_x),
    .term_xx             (term_xx),
    .term_y              (term_y),
    .term_yy             (term_yy),
    .term_xy             (term_xy),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_sample_total    (out_sample_total),
    .out_total_x         (out_total_x),
    .out_total_x_squared (out_total_x_squared),
    .out_total_y         (out_total_y),
    .out_total_y_squared (out_total_y_squared),
    .out_total_xy        (out_total_xy),
    .out_overflow        (out_overflow)
  );

endmodule

FILE: bench/stereo_correlation_accumulator_tb.sv
// Self-checking testbench for the stereo correlation moment accumulator.
`timescale 1ns / 1ps

module stereo_correlation_accumulator_tb;

  // A small count limit makes saturation reachable within a short run.
  localparam int COUNT_LIMIT_BITS = 8;
  localparam int HALF_PERIOD      = 10;
  localparam int SETTLE_CYCLES    = 6;
  localparam int LONG_HOLD_CYCLES = 80;
  localparam int NUM_PHASES       = 14;
  localparam int PHASE_PAIRS      = 85;
  localparam int PRESSURE_PHASE   = 5;
  localparam longint TIMEOUT_NS   = 5_000_000;

  // One set of block totals as it leaves the block.
  typedef struct {
    logic [scac_pkg::TOTAL_COUNT_BITS-1:0] sample_total;
    logic [scac_pkg::SUM_BITS-1:0]         total_x;
    logic [scac_pkg::SQ_BITS-1:0]          total_x_squared;
    logic [scac_pkg::SUM_BITS-1:0]         total_y;
    logic [scac_pkg::SQ_BITS-1:0]          total_y_squared;
    logic [scac_pkg::XY_BITS-1:0]          total_xy;
    logic                                  overflow;
  } moment_totals_t;

  // Tracks the moment sums of the block and holds the totals still to come out.
  class correlation_moments_model;
    bit                                  diff_mode;
    bit                                  mono_mode;
    bit [scac_pkg::TOTAL_COUNT_BITS-1:0] count;
    bit [scac_pkg::SUM_BITS-1:0]         sum_x;
    bit [scac_pkg::SUM_BITS-1:0]         sum_y;
    bit [scac_pkg::SQ_BITS-1:0]          sum_xx;
    bit [scac_pkg::SQ_BITS-1:0]          sum_yy;
    bit [scac_pkg::XY_BITS-1:0]          sum_xy;
    longint                              prev_left;
    longint                              prev_right;
    bit                                  dropped;
    moment_totals_t                      expected_totals[$];
    int                                  fails;
    int                                  results_checked;
    int                                  overflow_results;
    int                                  pairs_added;

    // Applies one accepted sample pair to the running sums.
    function void add_pair(logic signed [scac_pkg::SAMPLE_PORT_BITS-1:0] left,
                           logic signed [scac_pkg::SAMPLE_PORT_BITS-1:0] right,
                           bit start, bit last);
      longint         xv;
      longint         yv;
      moment_totals_t t;
      pairs_added++;
      if (start) begin
        count   = '0;
        sum_x   = '0;
        sum_y   = '0;
        sum_xx  = '0;
        sum_yy  = '0;
        sum_xy  = '0;
        dropped = 1'b0;
      end
      xv = diff_mode ? longint'(left) - prev_left : longint'(left);
      if (mono_mode)
        yv = xv;
      else
        yv = diff_mode ? longint'(right) - prev_right : longint'(right);
      // Once the count reaches its limit, samples are dropped and flagged.
      if (count >= (1 << COUNT_LIMIT_BITS) - 1) begin
        dropped = 1'b1;
      end else begin
        count  = count + 1'b1;
        sum_x  = sum_x + scac_pkg::SUM_BITS'(xv);
        sum_xx = sum_xx + scac_pkg::SQ_BITS'(xv * xv);
        sum_y  = sum_y + scac_pkg::SUM_BITS'(yv);
        sum_yy = sum_yy + scac_pkg::SQ_BITS'(yv * yv);
        sum_xy = sum_xy + scac_pkg::XY_BITS'(xv * yv);
      end
      // Previous samples survive the start flag; mono mode leaves the right one alone.
      prev_left = longint'(left);
      if (!mono_mode)
        prev_right = longint'(right);
      if (last) begin
        t = '{count, sum_x, sum_xx, sum_y, sum_yy, sum_xy, dropped};
        expected_totals.push_back(t);
      end
    endfunction

    function bit field_ok(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        return 1'b0;
      end
      return 1'b1;
    endfunction

    // Compares one result transfer against the oldest pending totals.
    function void check_totals(moment_totals_t got);
      moment_totals_t want;
      bit             ok;
      if (expected_totals.size() == 0) begin
        $display("%0t ns: result transfer with no totals pending, expected none, actual count %0d",
                 $time, got.sample_total);
        fails++;
        return;
      end
      want = expected_totals.pop_front();
      ok = field_ok("sample_total", want.sample_total, got.sample_total)
         & field_ok("total_x", want.total_x, got.total_x)
         & field_ok("total_x_squared", want.total_x_squared, got.total_x_squared)
         & field_ok("total_y", want.total_y, got.total_y)
         & field_ok("total_y_squared", want.total_y_squared, got.total_y_squared)
         & field_ok("total_xy", want.total_xy, got.total_xy)
         & field_ok("overflow", want.overflow, got.overflow);
      if (!ok)
        fails++;
      results_checked++;
      if (got.overflow === 1'b1)
        overflow_results++;
    endfunction
  endclass

  logic                                         clk;
  logic                                         rst_n;
  logic                                         psel;
  logic                                         penable;
  logic                                         pwrite;
  logic [scac_pkg::APB_ADDR_BITS-1:0]           paddr;
  logic [scac_pkg::APB_DATA_BITS-1:0]           pwdata;
  logic [scac_pkg::APB_DATA_BITS-1:0]           prdata;
  logic                                         pready;
  logic                                         in_valid;
  logic                                         in_stall;
  logic signed [scac_pkg::SAMPLE_PORT_BITS-1:0] in_left_sample;
  logic signed [scac_pkg::SAMPLE_PORT_BITS-1:0] in_right_sample;
  logic                                         in_start_block;
  logic                                         in_last_sample;
  logic                                         out_valid;
  logic                                         out_stall;
  logic        [scac_pkg::TOTAL_COUNT_BITS-1:0] out_sample_total;
  logic signed [scac_pkg::SUM_BITS-1:0]         out_total_x;
  logic        [scac_pkg::SQ_BITS-1:0]          out_total_x_squared;
  logic signed [scac_pkg::SUM_BITS-1:0]         out_total_y;
  logic        [scac_pkg::SQ_BITS-1:0]          out_total_y_squared;
  logic signed [scac_pkg::XY_BITS-1:0]          out_total_xy;
  logic                                         out_overflow;

  correlation_moments_model model = new();

  bit send_gaps;
  bit stall_bursts;
  bit long_hold_req;
  int mode_settings;

  stereo_correlation_accumulator #(
    .COUNT_BITS (COUNT_LIMIT_BITS),
    .SAMPLE_BITS(scac_pkg::SAMPLE_PORT_BITS)
  ) dut (.*);

  // Free-running clock.
  initial clk = 1'b0;
  always #HALF_PERIOD clk = ~clk;

  // Run limit.
  initial begin
    #(TIMEOUT_NS);
    $display("stereo_correlation_accumulator_tb: FAIL");
    $finish;
  end

  // Checks every result transfer.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      model.check_totals('{out_sample_total, out_total_x, out_total_x_squared, out_total_y,
                           out_total_y_squared, out_total_xy, out_overflow});
  end

  // Receiver stall: random bursts, plus one long hold on request.
  initial begin
    out_stall = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(negedge clk);
        out_stall <= 1'b0;
      end else if (stall_bursts && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 9)) @(negedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  function automatic logic signed [scac_pkg::SAMPLE_PORT_BITS-1:0] pick_sample();
    unique case ($urandom_range(0, 9))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2:       return 16'sh0000;
      3:       return 16'shffff;
      default: return 16'($urandom);
    endcase
  endfunction

  // Offers one sample pair and waits for its transfer; returns on a falling edge.
  task automatic send_pair(logic signed [scac_pkg::SAMPLE_PORT_BITS-1:0] left,
                           logic signed [scac_pkg::SAMPLE_PORT_BITS-1:0] right,
                           bit start, bit last);
    if (send_gaps && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_left_sample  <= left;
    in_right_sample <= right;
    in_start_block  <= start;
    in_last_sample  <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    model.add_pair(left, right, start, last);
    @(negedge clk);
  endtask

  // Sends one block of random pairs with occasional stray framing flags.
  task automatic send_block(int len, bit with_start, bit with_last);
    bit s;
    bit l;
    for (int i = 0; i < len; i++) begin
      s = (i == 0) ? with_start : ($urandom_range(0, 29) == 0);
      l = (i == len - 1) ? with_last : ($urandom_range(0, 29) == 0);
      send_pair(pick_sample(), pick_sample(), s, l);
    end
  endtask

  // Stops offering pairs and waits until every pending total has come out.
  task automatic pause_input();
    in_valid <= 1'b0;
    while (model.expected_totals.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Writes one mode register, then reads it back.
  task automatic cfg_write(scac_pkg::reg_idx_t idx, bit value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= scac_pkg::APB_ADDR_BITS'({idx, 2'b00});
    pwdata  <= scac_pkg::APB_DATA_BITS'(value);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (idx == scac_pkg::REG_DIFFERENCE_MODE)
      model.diff_mode = value;
    else
      model.mono_mode = value;
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[0] !== value) begin
      $display("%0t ns: register %s read back, expected %0d, actual %0d",
               $time, idx.name(), value, prdata[0]);
      model.fails++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_modes(bit diff, bit mono);
    pause_input();
    cfg_write(scac_pkg::REG_DIFFERENCE_MODE, diff);
    cfg_write(scac_pkg::REG_MONO_MODE, mono);
    mode_settings++;
  endtask

  // Main stimulus.
  initial begin
    int sent;
    int len;
    rst_n           = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    in_valid        = 1'b0;
    in_left_sample  = '0;
    in_right_sample = '0;
    in_start_block  = 1'b0;
    in_last_sample  = 1'b0;
    send_gaps       = 1'b0;
    stall_bursts    = 1'b0;
    long_hold_req   = 1'b0;
    mode_settings   = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: totals straight out of reset, then sample extremes in plain mode.
    send_pair(16'sd100, -16'sd200, 1'b0, 1'b1);
    send_pair(16'sh8000, 16'sh8000, 1'b1, 1'b1);
    send_pair(16'sh7fff, 16'sh7fff, 1'b1, 1'b1);
    send_pair(16'sh8000, 16'sh7fff, 1'b1, 1'b1);
    send_pair(16'sh0000, 16'sh0000, 1'b1, 1'b0);
    send_pair(16'shffff, 16'sh0001, 1'b0, 1'b0);
    send_pair(16'sh7fff, 16'sh8000, 1'b0, 1'b1);
    // Emission does not clear, so this keeps adding to the same block.
    send_pair(16'sd5, 16'sd7, 1'b0, 1'b1);
    // Difference mode with the largest swings in both directions.
    set_modes(1'b1, 1'b0);
    send_pair(16'sh7fff, 16'sh8000, 1'b1, 1'b0);
    send_pair(16'sh8000, 16'sh7fff, 1'b0, 1'b1);
    send_pair(16'sh0000, 16'sh0000, 1'b1, 1'b1);
    // Mono mode ignores the right channel.
    set_modes(1'b0, 1'b1);
    send_pair(16'sh8000, 16'sd1234, 1'b1, 1'b1);
    send_pair(16'sh7fff, 16'shffff, 1'b1, 1'b0);
    send_pair(-16'sd5, 16'sd77, 1'b0, 1'b1);
    // Mono with differences; the right history must stay untouched.
    set_modes(1'b1, 1'b1);
    send_pair(16'sh8000, 16'sh0000, 1'b1, 1'b0);
    send_pair(16'sh7fff, 16'sh0000, 1'b0, 1'b1);
    set_modes(1'b1, 1'b0);
    send_pair(16'sd1, 16'sd1, 1'b1, 1'b1);

    // Random phases, each under its own mode setting.
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p < 4)
        set_modes(p[0], p[1]);
      else
        set_modes($urandom_range(0, 1), $urandom_range(0, 1));
      send_gaps    = (p < NUM_PHASES - 2) && ($urandom_range(0, 3) != 0);
      stall_bursts = (p < NUM_PHASES - 2) && ($urandom_range(0, 3) != 0);
      sent = 0;
      if (p == PRESSURE_PHASE) begin
        // Receiver holds off while single-pair blocks keep coming.
        send_gaps     = 1'b0;
        stall_bursts  = 1'b0;
        long_hold_req = 1'b1;
        repeat (40) send_pair(pick_sample(), pick_sample(), 1'b1, 1'b1);
        sent = 40;
      end
      if (p == 2 || p == 9) begin
        // A block longer than the count limit.
        len = $urandom_range(256, 300);
        send_block(len, 1'b1, 1'b1);
        sent += len;
      end
      while (sent < PHASE_PAIRS) begin
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
        send_block(len, $urandom_range(0, 7) != 0, $urandom_range(0, 15) != 0);
        sent += len;
      end
    end

    send_gaps    = 1'b0;
    stall_bursts = 1'b0;
    pause_input();
    $display("Covered %0d sample pairs under %0d mode settings, all four mode combinations.",
             model.pairs_added, mode_settings);
    $display("Checked %0d block totals, %0d of them with the count saturated.",
             model.results_checked, model.overflow_results);
    if (model.fails == 0 && model.expected_totals.size() == 0) begin
      $display("stereo_correlation_accumulator_tb: PASS");
    end else begin
      $display("stereo_correlation_accumulator_tb: FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/scac_pkg.sv
hdl/scac_cfg_regs.sv
hdl/scac_front.sv
hdl/scac_accum.sv
hdl/stereo_correlation_accumulator.sv
bench/stereo_correlation_accumulator_tb.sv
